/* rtl/pgg_pkg.sv */
package pgg_pkg;

    // Stream bank size and index width
    localparam int NUM_STREAMS = 8;
    localparam int IDX_W = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;

    // Generator and seeding constants
    localparam logic [31:0] SEED_STRIDE = 32'd314159;
    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [30:0] LCG_ADD = 31'd12345;
    localparam logic [63:0] TWO_LN2_Q62 = 64'h58B9_0BFB_E8E7_BCD6;

    // Iteration counts of the shared units and the last multiply step
    localparam int LOG_BITS = 56;
    localparam int DIV_BITS = 128;
    localparam int SQRT_STEPS = 32;
    localparam int MUL_LAST = 4;

    // Datapath operations
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_DRAW1,
        OP_DRAW2,
        OP_SQ1,
        OP_SQ2,
        OP_SUM,
        OP_NORM_LOAD,
        OP_NORM_SHIFT,
        OP_LOG_INIT,
        OP_MUL,
        OP_LOG_STEP,
        OP_G_INIT,
        OP_G_TAKE,
        OP_SC_SQ,
        OP_SC_MUL_INIT,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_SC_TAKE,
        OP_RESULT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] mstep;
        logic [6:0] cnt;
        logic       sel;
        logic       cfg_we;
    } dp_cmd_t;

    typedef struct packed {
        logic cache_full;
        logic r_bad;
        logic m_top;
        logic out_busy;
    } dp_status_t;

endpackage

/* rtl/pgg_datapath.sv */
module pgg_datapath
    import pgg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic                action,
    input  logic [2:0]          stream,
    input  logic [31:0]         cfg_data,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic signed [31:0]  first_value,
    output logic signed [31:0]  second_value,
    output logic                second_valid
);

    logic [31:0]      seeds_reg [NUM_STREAMS];
    logic [IDX_W-1:0] idx_reg;
    logic             action_reg;
    logic             hit_reg;
    logic [31:0]      v1_reg, v2_reg;
    logic [63:0]      prod_reg;
    logic [61:0]      r_reg;
    logic [63:0]      m_reg;
    logic [6:0]       shcnt_reg;
    logic [55:0]      frac_reg;
    logic [63:0]      ma_reg, mb_reg;
    logic [127:0]     acc_reg;
    logic [63:0]      g_reg;
    logic [63:0]      rem_reg;
    logic [63:0]      n_reg, res_reg;
    logic [31:0]      dev_first_reg, dev_second_reg;
    logic [31:0]      cache_reg;
    logic             cache_full_reg;
    logic             out_valid_reg;
    logic [31:0]      first_reg, second_reg;
    logic             sv_reg;

    logic [31:0]      mul_a, mul_b;
    logic [63:0]      mul_p;
    logic [30:0]      s_new;
    logic [31:0]      v_sel, mag;
    logic [IDX_W-1:0] idx_in;
    logic [2:0]       pstep;
    logic [127:0]     part_sh;
    logic [63:0]      sq;
    logic [63:0]      log_l;
    logic [63:0]      rem_sh;
    logic             div_ge;
    logic [5:0]       sq_shamt;
    logic [63:0]      sq_bit, sq_trial;
    logic [31:0]      o_mag;
    logic [31:0]      dev;

    // Stream index of a request, clamped to the bank
    assign idx_in = (32'(stream) >= NUM_STREAMS) ? IDX_W'(NUM_STREAMS - 1) : IDX_W'(stream);

    // Magnitude of the selected uniform (first deviate uses the second draw)
    assign v_sel = cmd.sel ? v1_reg : v2_reg;

    always_comb
    begin
        case (cmd.op)
            OP_SQ1:  mag = v1_reg[31] ? (32'd0 - v1_reg) : v1_reg;
            OP_SQ2:  mag = v2_reg[31] ? (32'd0 - v2_reg) : v2_reg;
            default: mag = v_sel[31] ? (32'd0 - v_sel) : v_sel;
        endcase
    end

    // Shared 32x32 multiplier operand selection
    always_comb
    begin
        case (cmd.op)
            OP_DRAW1, OP_DRAW2:
            begin
                mul_a = seeds_reg[idx_reg];
                mul_b = LCG_MUL;
            end
            OP_SQ1, OP_SQ2, OP_SC_SQ:
            begin
                mul_a = mag;
                mul_b = mag;
            end
            OP_MUL:
            begin
                mul_a = cmd.mstep[1] ? ma_reg[63:32] : ma_reg[31:0];
                mul_b = cmd.mstep[0] ? mb_reg[63:32] : mb_reg[31:0];
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 32'd0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign s_new = mul_p[30:0] + LCG_ADD;

    // Partial product from the previous step, placed at its weight
    assign pstep = cmd.mstep - 3'd1;

    always_comb
    begin
        case (pstep)
            3'd0:    part_sh = {64'd0, prod_reg};
            3'd1,
            3'd2:    part_sh = {32'd0, prod_reg, 32'd0};
            3'd3:    part_sh = {prod_reg, 64'd0};
            default: part_sh = 128'd0;
        endcase
    end

    // Logarithm squaring result and the value -log2 r
    assign sq = acc_reg[125:62];
    assign log_l = ((64'(shcnt_reg) - 64'd2) << LOG_BITS) - {8'd0, frac_reg};

    // Restoring division step
    assign rem_sh = {rem_reg[62:0], acc_reg[127]};
    assign div_ge = rem_sh >= {2'b00, r_reg};

    // Square root trial
    assign sq_shamt = 6'd62 - {cmd.cnt[4:0], 1'b0};
    assign sq_bit = 64'd1 << sq_shamt;
    assign sq_trial = res_reg + sq_bit;

    // Rounded Q4.27 deviate with the sign of its uniform
    assign o_mag = 32'((res_reg + 64'd1) >> 1);
    assign dev = v_sel[31] ? (32'd0 - o_mag) : o_mag;

    // Stream seeds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STREAMS; i++)
            begin
                seeds_reg[i] <= 32'(i) * SEED_STRIDE;
            end
        end
        else if (cmd.cfg_we)
        begin
            for (int i = 0; i < NUM_STREAMS; i++)
            begin
                seeds_reg[i] <= cfg_data + 32'(i) * SEED_STRIDE;
            end
        end
        else if (cmd.op == OP_DRAW1 || cmd.op == OP_DRAW2)
        begin
            seeds_reg[idx_reg] <= {1'b0, s_new};
        end
    end

    // Control state: cache and result channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cache_full_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_RESULT)
            begin
                out_valid_reg <= 1'b1;
                if (!action_reg)
                begin
                    cache_full_reg <= !hit_reg;
                end
            end
            else if (out_valid_reg && !rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Arithmetic working registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LATCH:
            begin
                idx_reg <= idx_in;
                action_reg <= action;
                hit_reg <= !action && cache_full_reg;
            end
            OP_DRAW1:
            begin
                v1_reg <= {1'b0, s_new} - 32'h4000_0000;
            end
            OP_DRAW2:
            begin
                v2_reg <= {1'b0, s_new} - 32'h4000_0000;
            end
            OP_SQ1:
            begin
                prod_reg <= mul_p;
            end
            OP_SQ2:
            begin
                prod_reg <= mul_p;
                r_reg <= prod_reg[61:0];
            end
            OP_SUM:
            begin
                r_reg <= r_reg + prod_reg[61:0];
            end
            OP_NORM_LOAD:
            begin
                m_reg <= {2'b00, r_reg};
                shcnt_reg <= 7'd0;
            end
            OP_NORM_SHIFT:
            begin
                m_reg <= {m_reg[62:0], 1'b0};
                shcnt_reg <= shcnt_reg + 7'd1;
            end
            OP_LOG_INIT:
            begin
                frac_reg <= 56'd0;
                ma_reg <= m_reg;
                mb_reg <= m_reg;
                acc_reg <= 128'd0;
            end
            OP_MUL:
            begin
                if (cmd.mstep != 3'(MUL_LAST))
                begin
                    prod_reg <= mul_p;
                end
                if (cmd.mstep != 3'd0)
                begin
                    acc_reg <= acc_reg + part_sh;
                end
            end
            OP_LOG_STEP:
            begin
                m_reg <= sq[63] ? {1'b0, sq[63:1]} : sq;
                ma_reg <= sq[63] ? {1'b0, sq[63:1]} : sq;
                mb_reg <= sq[63] ? {1'b0, sq[63:1]} : sq;
                frac_reg <= {frac_reg[54:0], sq[63]};
                acc_reg <= 128'd0;
            end
            OP_G_INIT:
            begin
                ma_reg <= log_l;
                mb_reg <= TWO_LN2_Q62;
                acc_reg <= 128'd0;
            end
            OP_G_TAKE:
            begin
                g_reg <= sq;
            end
            OP_SC_SQ:
            begin
                prod_reg <= mul_p;
            end
            OP_SC_MUL_INIT:
            begin
                ma_reg <= prod_reg;
                mb_reg <= g_reg;
                acc_reg <= 128'd0;
            end
            OP_DIV_INIT:
            begin
                rem_reg <= 64'd0;
            end
            OP_DIV_STEP:
            begin
                rem_reg <= div_ge ? (rem_sh - {2'b00, r_reg}) : rem_sh;
                acc_reg <= {acc_reg[126:0], div_ge};
            end
            OP_SQRT_INIT:
            begin
                n_reg <= acc_reg[63:0];
                res_reg <= 64'd0;
            end
            OP_SQRT_STEP:
            begin
                if (n_reg >= sq_trial)
                begin
                    n_reg <= n_reg - sq_trial;
                    res_reg <= (res_reg >> 1) + sq_bit;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
            end
            OP_SC_TAKE:
            begin
                if (cmd.sel)
                begin
                    dev_second_reg <= dev;
                end
                else
                begin
                    dev_first_reg <= dev;
                end
            end
            OP_RESULT:
            begin
                if (action_reg)
                begin
                    first_reg <= dev_first_reg;
                    second_reg <= dev_second_reg;
                    sv_reg <= 1'b1;
                end
                else if (hit_reg)
                begin
                    first_reg <= cache_reg;
                    second_reg <= 32'd0;
                    sv_reg <= 1'b0;
                end
                else
                begin
                    first_reg <= dev_first_reg;
                    second_reg <= 32'd0;
                    sv_reg <= 1'b0;
                    cache_reg <= dev_second_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Status back to the controller
    assign status.cache_full = cache_full_reg;
    assign status.r_bad = (r_reg == 62'd0) || (r_reg[61:60] != 2'b00);
    assign status.m_top = m_reg[62];
    assign status.out_busy = out_valid_reg && rsp_stall;

    assign rsp_valid = out_valid_reg;
    assign first_value = first_reg;
    assign second_value = second_reg;
    assign second_valid = sv_reg;

endmodule

/* rtl/pgg_controller.sv */
module pgg_controller
    import pgg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_stall,
    input  logic       action,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_DRAW1,
        S_DRAW2,
        S_SQ1,
        S_SQ2,
        S_SUM,
        S_CHECK,
        S_NORM,
        S_LOGI,
        S_LMUL,
        S_LSTEP,
        S_GINIT,
        S_GMUL,
        S_GTAKE,
        S_SSQ,
        S_SMI,
        S_SMUL,
        S_DIVI,
        S_DIV,
        S_SQI,
        S_SQRT,
        S_STAKE,
        S_DONE
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] mstep_reg, mstep_next;
    logic [6:0] cnt_reg, cnt_next;
    logic       sel_reg, sel_next;
    op_t        op;

    // Next state and operation decode
    always_comb
    begin
        state_next = state_reg;
        mstep_next = mstep_reg;
        cnt_next = cnt_reg;
        sel_next = sel_reg;
        op = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op = OP_LATCH;
                    state_next = (!action && status.cache_full) ? S_DONE : S_DRAW1;
                end
            end
            S_DRAW1:
            begin
                op = OP_DRAW1;
                state_next = S_DRAW2;
            end
            S_DRAW2:
            begin
                op = OP_DRAW2;
                state_next = S_SQ1;
            end
            S_SQ1:
            begin
                op = OP_SQ1;
                state_next = S_SQ2;
            end
            S_SQ2:
            begin
                op = OP_SQ2;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                op = OP_SUM;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                op = OP_NORM_LOAD;
                state_next = status.r_bad ? S_DRAW1 : S_NORM;
            end
            S_NORM:
            begin
                if (status.m_top)
                begin
                    state_next = S_LOGI;
                end
                else
                begin
                    op = OP_NORM_SHIFT;
                end
            end
            S_LOGI:
            begin
                op = OP_LOG_INIT;
                cnt_next = 7'd0;
                mstep_next = 3'd0;
                state_next = S_LMUL;
            end
            S_LMUL, S_GMUL, S_SMUL:
            begin
                op = OP_MUL;
                mstep_next = mstep_reg + 3'd1;
                if (mstep_reg == 3'(MUL_LAST))
                begin
                    mstep_next = 3'd0;
                    case (state_reg)
                        S_LMUL:  state_next = S_LSTEP;
                        S_GMUL:  state_next = S_GTAKE;
                        default: state_next = S_DIVI;
                    endcase
                end
            end
            S_LSTEP:
            begin
                op = OP_LOG_STEP;
                cnt_next = cnt_reg + 7'd1;
                state_next = (cnt_reg == 7'(LOG_BITS - 1)) ? S_GINIT : S_LMUL;
            end
            S_GINIT:
            begin
                op = OP_G_INIT;
                mstep_next = 3'd0;
                state_next = S_GMUL;
            end
            S_GTAKE:
            begin
                op = OP_G_TAKE;
                sel_next = 1'b0;
                state_next = S_SSQ;
            end
            S_SSQ:
            begin
                op = OP_SC_SQ;
                state_next = S_SMI;
            end
            S_SMI:
            begin
                op = OP_SC_MUL_INIT;
                mstep_next = 3'd0;
                state_next = S_SMUL;
            end
            S_DIVI:
            begin
                op = OP_DIV_INIT;
                cnt_next = 7'd0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                op = OP_DIV_STEP;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(DIV_BITS - 1))
                begin
                    state_next = S_SQI;
                end
            end
            S_SQI:
            begin
                op = OP_SQRT_INIT;
                cnt_next = 7'd0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                op = OP_SQRT_STEP;
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == 7'(SQRT_STEPS - 1))
                begin
                    state_next = S_STAKE;
                end
            end
            S_STAKE:
            begin
                op = OP_SC_TAKE;
                sel_next = 1'b1;
                state_next = sel_reg ? S_DONE : S_SSQ;
            end
            S_DONE:
            begin
                if (!status.out_busy)
                begin
                    op = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and sequencing counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mstep_reg <= 3'd0;
            cnt_reg <= 7'd0;
            sel_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mstep_reg <= mstep_next;
            cnt_reg <= cnt_next;
            sel_reg <= sel_next;
        end
    end

    // Commands to the datapath
    assign req_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign cmd.op = op;
    assign cmd.mstep = mstep_reg;
    assign cmd.cnt = cnt_reg;
    assign cmd.sel = sel_reg;
    assign cmd.cfg_we = cfg_valid && (state_reg == S_IDLE);

endmodule

/* rtl/polar_gaussian_generator.sv */
// Gaussian deviate generator (polar method over a bank of linear congruential
// streams). A request carries action and stream on req_valid/req_stall; a
// response carries first_value, second_value and second_valid on
// rsp_valid/rsp_stall. The stream seeds are written on cfg_valid/cfg_ready
// with cfg_data; cfg_ready is high only while no request is in work.
// A single-mode request may be served from the deviate cache. Any other
// request draws pairs again until one is accepted, then runs normalizing
// shifts, 56 logarithm rounds on the shared 32x32 multiplier, and per
// deviate a restoring divider and a square root unit.
// One request is in work at a time; req_stall stays high from acceptance
// until the response is loaded into the output register.
// Reset clears the cache, empties the output register and loads stream i
// with i*314159. While the receiver stalls, the response holds steady and a
// finished next response waits in the last state until the register frees.
module polar_gaussian_generator
    import pgg_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic               action,
    input  logic [2:0]         stream,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic signed [31:0] first_value,
    output logic signed [31:0] second_value,
    output logic               second_valid,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer
    pgg_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .action    (action),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and state
    pgg_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .stream       (stream),
        .cfg_data     (cfg_data),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .first_value  (first_value),
        .second_value (second_value),
        .second_valid (second_valid)
    );

endmodule

/* rtl/pgg_checker.sv */
module pgg_checker
    import pgg_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic signed [31:0] first_value,
    input logic signed [31:0] second_value,
    input logic               second_valid,
    input logic               cfg_ready
);

    // A stalled response holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(first_value)
            && $stable(second_value) && $stable(second_valid)))
        else $error("stalled response changed");

    // An accepted request closes the request channel for the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> req_stall)
        else $error("request channel open right after acceptance");

    // Single-mode responses carry no second deviate.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !second_valid) |-> (second_value == 32'sd0))
        else $error("second value set in single mode");

    // Configuration is taken exactly when requests are.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready != req_stall)
        else $error("configuration and request readiness disagree");

endmodule

bind polar_gaussian_generator pgg_checker u_pgg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .first_value  (first_value),
    .second_value (second_value),
    .second_valid (second_valid),
    .cfg_ready    (cfg_ready)
);
